// ===== rtl/core/ipd_frame_deframer_assert.svh =====
// assertion macros used by the checker file
`ifndef IPD_FRAME_DEFRAMER_ASSERT_SVH
`define IPD_FRAME_DEFRAMER_ASSERT_SVH

// property checked outside reset
`define IPD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipd assertion failed");

// property checked on every edge, reset included
`define IPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipd assertion failed");

`endif

// ===== rtl/core/ipd_pkg.sv =====
package ipd_pkg;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [2:0] TAG_LEN  = 3'd3;
  localparam logic [2:0] TAG_SAT  = 3'd4;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_TAG    = 5'b00010,
    PH_ID     = 5'b00100,
    PH_LEN    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_first;
    logic       payload_last;
  } beat_t;

  // expected tag text "IPD"
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h49;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ipd_rx_if.sv =====
interface ipd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/ipd_pl_if.sv =====
interface ipd_pl_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_first;
  logic       payload_last;

  modport source (output valid, output payload_byte, output payload_first,
                  output payload_last, input ready);
  modport sink (input valid, input payload_byte, input payload_first,
                input payload_last, output ready);
endinterface

// ===== rtl/core/ipd_parser.sv =====
module ipd_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output ipd_pkg::beat_t    res
);

  localparam int PW = LENGTH_BITS + 4;

  ipd_pkg::phase_t          phase, phase_next;
  logic [2:0]               tag_position, tag_position_next;
  logic                     tag_mismatch, tag_mismatch_next;
  logic [LENGTH_BITS-1:0]   length_value, length_value_next;
  logic                     length_stopped, length_stopped_next;
  logic [LENGTH_BITS-1:0]   bytes_left, bytes_left_next;

  logic [PW-1:0]            len_ext;
  logic [PW-1:0]            len_acc;
  logic [LENGTH_BITS-1:0]   len_sat;
  logic [LENGTH_BITS-1:0]   left_dec;

  // len * 10 + digit, saturating
  assign len_ext  = PW'(length_value);
  assign len_acc  = (len_ext << 3) + (len_ext << 1) + PW'(rx_byte[3:0]);
  assign len_sat  = (len_acc[PW-1:LENGTH_BITS] != '0) ? '1 : len_acc[LENGTH_BITS-1:0];
  assign left_dec = bytes_left - LENGTH_BITS'(bytes_left != '0);

  always_comb begin
    phase_next          = phase;
    tag_position_next   = tag_position;
    tag_mismatch_next   = tag_mismatch;
    length_value_next   = length_value;
    length_stopped_next = length_stopped;
    bytes_left_next     = bytes_left;
    res_valid           = 1'b0;
    res                 = '0;
    case (phase)
      ipd_pkg::PH_TAG: begin
        if (rx_byte == ipd_pkg::CHAR_COMMA) begin
          phase_next = (!tag_mismatch && tag_position == ipd_pkg::TAG_LEN) ?
                       ipd_pkg::PH_ID : ipd_pkg::PH_SEARCH;
        end else begin
          if (tag_position >= ipd_pkg::TAG_LEN ||
              rx_byte != ipd_pkg::tag_char(tag_position)) begin
            tag_mismatch_next = 1'b1;
          end
          if (tag_position < ipd_pkg::TAG_SAT) begin
            tag_position_next = tag_position + 3'd1;
          end
        end
      end
      ipd_pkg::PH_ID: begin
        if (rx_byte == ipd_pkg::CHAR_COMMA) begin
          phase_next          = ipd_pkg::PH_LEN;
          length_value_next   = '0;
          length_stopped_next = 1'b0;
        end
      end
      ipd_pkg::PH_LEN: begin
        if (rx_byte == ipd_pkg::CHAR_COLON) begin
          if (length_value == '0) begin
            phase_next = ipd_pkg::PH_SEARCH;
          end else begin
            bytes_left_next = length_value;
            phase_next      = ipd_pkg::PH_DATA;
          end
        end else if (!length_stopped) begin
          if (rx_byte inside {[ipd_pkg::CHAR_ZERO:ipd_pkg::CHAR_NINE]}) begin
            length_value_next = len_sat;
          end else begin
            length_stopped_next = 1'b1;
          end
        end
      end
      ipd_pkg::PH_DATA: begin
        res_valid         = 1'b1;
        res.payload_byte  = rx_byte;
        res.payload_first = (bytes_left == length_value);
        res.payload_last  = (bytes_left <= LENGTH_BITS'(1));
        bytes_left_next   = left_dec;
        if (left_dec == '0) begin
          phase_next = ipd_pkg::PH_SEARCH;
        end
      end
      default: begin
        phase_next = ipd_pkg::PH_SEARCH;
        if (rx_byte == ipd_pkg::CHAR_PLUS) begin
          phase_next        = ipd_pkg::PH_TAG;
          tag_position_next = '0;
          tag_mismatch_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ipd_pkg::PH_SEARCH;
      tag_position   <= '0;
      tag_mismatch   <= 1'b0;
      length_value   <= '0;
      length_stopped <= 1'b0;
      bytes_left     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      tag_position   <= tag_position_next;
      tag_mismatch   <= tag_mismatch_next;
      length_value   <= length_value_next;
      length_stopped <= length_stopped_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/core/ipd_out_reg.sv =====
module ipd_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  ipd_pkg::beat_t  beat,
  output logic            open,
  ipd_pl_if.source        pl
);

  logic           valid;
  ipd_pkg::beat_t data;

  // register can take a beat when empty or being drained this cycle
  assign open = !valid || pl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (open) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (open && load) begin
      data <= beat;
    end
  end

  assign pl.valid         = valid;
  assign pl.payload_byte  = data.payload_byte;
  assign pl.payload_first = data.payload_first;
  assign pl.payload_last  = data.payload_last;

endmodule

// ===== rtl/core/ipd_frame_deframer.sv =====
// ipd_frame_deframer: pulls payload data out of modem "+IPD,id,len:data" frames
//
// rx channel: one received modem byte per beat (rx_byte)
// pl channel: one payload byte per beat, with payload_first on the first byte
//   of a frame and payload_last on its final byte
// bytes outside a frame (search, tag, id, length fields) produce no beat
//
// path: a byte accepted on rx is held in the input register, parsed when the output
//   register can take it, and its payload beat is then registered in the output
//   register and presented on pl
// throughput: one byte per cycle while pl takes its beats, set by the single parse
//   step between the input register and the output register
// reset (synchronous, active high): parser returns to searching for '+',
//   both the input and output registers are emptied
// stall: when pl is held off the output register keeps its beat, the input
//   register fills and rx.ready drops until the output beat is taken; no
//   beat is dropped or repeated
// LENGTH_BITS sets the frame length counter; longer lengths saturate
module ipd_frame_deframer #(
  parameter int LENGTH_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  ipd_rx_if.sink   rx,
  ipd_pl_if.source pl
);

  // input register
  logic           in_valid;
  logic [7:0]     in_byte;

  logic           out_open;
  logic           step;
  logic           res_valid;
  ipd_pkg::beat_t res;

  // the held byte moves through the parser when the output stage can take it
  assign step     = in_valid && out_open;
  assign rx.ready = !in_valid || out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  // frame state machine and length counter
  ipd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register toward the payload sink
  ipd_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (step && res_valid),
    .beat (res),
    .open (out_open),
    .pl   (pl)
  );

endmodule

// ===== rtl/core/ipd_frame_deframer_checker.sv =====
`include "ipd_frame_deframer_assert.svh"

module ipd_frame_deframer_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       pl_valid,
  input logic       pl_ready,
  input logic [7:0] pl_byte,
  input logic       pl_first,
  input logic       pl_last
);

  logic       rx_beat;
  logic       rx_stall;
  logic       pl_beat;
  logic [9:0] pl_word;
  logic       out_cause;

  assign rx_beat   = rx_valid && rx_ready;
  assign rx_stall  = rx_valid && !rx_ready;
  assign pl_beat   = pl_valid && pl_ready;
  assign pl_word   = {pl_byte, pl_first, pl_last};
  // an input beat taken, an input beat held off, or an output beat waiting
  assign out_cause = rx_beat || rx_stall || pl_valid;

  // a stalled output beat keeps its payload
  `IPD_ASSERT(a_pl_hold, clk, rst, ((pl_valid && !pl_ready) |=> (pl_valid && $stable(pl_word))))

  // reset empties the output stage
  `IPD_ASSERT_ALWAYS(a_rst_empty, clk, (rst |=> !pl_valid))

  // a frame that is not finished never restarts on the next beat
  `IPD_ASSERT(a_no_restart, clk, rst, ((pl_beat && !pl_last) |=> !(pl_valid && pl_first)))

  // an output beat can only follow an earlier input beat, taken or held off, or a held output beat
  `IPD_ASSERT(a_out_cause, clk, rst, ($rose(pl_valid) |-> $past(out_cause, 2)))

endmodule

bind ipd_frame_deframer ipd_frame_deframer_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_valid (rx.valid),
  .rx_ready (rx.ready),
  .pl_valid (pl.valid),
  .pl_ready (pl.ready),
  .pl_byte  (pl.payload_byte),
  .pl_first (pl.payload_first),
  .pl_last  (pl.payload_last)
);

// ===== sim/testbench.sv =====
module testbench;

  // length counter width used for the block and for the prediction
  localparam int LEN_BITS = 16;
  localparam int unsigned LEN_MAX = (1 << LEN_BITS) - 1;
  // tag text, first character in the top byte
  localparam logic [23:0] TAG_WORD = "IPD";
  // non-noise bytes wanted from the random part
  localparam int RANDOM_ITEMS = 900;
  // drain the block after this many non-noise random bytes
  localparam int DRAIN_EVERY = 300;
  // settling margin after the last predicted beat, used when draining
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_IDLE = 12;
  // payload bytes sent into the saturated frame
  localparam int SAT_SLICE = 40;

  logic clk;
  logic rst;

  ipd_rx_if rx();
  ipd_pl_if pl();

  ipd_frame_deframer #(
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rx (rx),
    .pl (pl)
  );

  // free-running clock, period 10
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state as predicted from the accepted byte stream
  ipd_pkg::phase_t     parse_ph;
  logic [2:0]          tag_cnt;
  logic                tag_bad;
  logic [LEN_BITS-1:0] frame_len;
  logic                len_done;
  logic [LEN_BITS-1:0] remaining;

  // payload beats predicted but not yet seen on pl
  ipd_pkg::beat_t expected_payload[$];

  // run statistics
  int  rx_count;
  int  noise_count;
  int  frames_opened;
  int  zero_frames;
  int  beats_checked;
  int  err_count;
  // when set, neither side idles
  bit  no_idle;
  int  ready_gap;
  ipd_pkg::beat_t seen_beat;
  ipd_pkg::beat_t want_beat;

  // -------------------------------------------------------------------------
  // prediction
  // -------------------------------------------------------------------------

  task automatic clear_parser();
    parse_ph  = ipd_pkg::PH_SEARCH;
    tag_cnt   = '0;
    tag_bad   = 1'b0;
    frame_len = '0;
    len_done  = 1'b0;
    remaining = '0;
  endtask

  // advance the parser by one accepted byte, queue a payload beat if one is due
  task automatic deframe_step(input logic [7:0] b);
    int unsigned    acc;
    ipd_pkg::beat_t beat;
    case (parse_ph)
      ipd_pkg::PH_TAG: begin
        if (b == ipd_pkg::CHAR_COMMA) begin
          // only an exact three-letter tag moves on
          parse_ph = (!tag_bad && tag_cnt == ipd_pkg::TAG_LEN) ?
                     ipd_pkg::PH_ID : ipd_pkg::PH_SEARCH;
        end else begin
          // a plus sign here is just another tag character
          if (tag_cnt >= ipd_pkg::TAG_LEN) begin
            tag_bad = 1'b1;
          end else if (b != TAG_WORD[23 - 8*tag_cnt -: 8]) begin
            tag_bad = 1'b1;
          end
          if (tag_cnt < ipd_pkg::TAG_SAT) tag_cnt = tag_cnt + 3'd1;
        end
      end
      ipd_pkg::PH_ID: begin
        // connection id is skipped whatever it holds
        if (b == ipd_pkg::CHAR_COMMA) begin
          parse_ph  = ipd_pkg::PH_LEN;
          frame_len = '0;
          len_done  = 1'b0;
        end
      end
      ipd_pkg::PH_LEN: begin
        if (b == ipd_pkg::CHAR_COLON) begin
          if (frame_len == 0) begin
            // empty frame, nothing to emit
            parse_ph = ipd_pkg::PH_SEARCH;
            zero_frames++;
          end else begin
            remaining = frame_len;
            parse_ph  = ipd_pkg::PH_DATA;
            frames_opened++;
          end
        end else if (!len_done) begin
          if (b >= ipd_pkg::CHAR_ZERO && b <= ipd_pkg::CHAR_NINE) begin
            acc = frame_len * 10 + (b - ipd_pkg::CHAR_ZERO);
            // saturate at the counter maximum
            frame_len = (acc > LEN_MAX) ? LEN_MAX[LEN_BITS-1:0] : acc[LEN_BITS-1:0];
          end else begin
            // first non-digit freezes the length
            len_done = 1'b1;
          end
        end
      end
      ipd_pkg::PH_DATA: begin
        // delimiters in here are plain data
        beat.payload_byte  = b;
        beat.payload_first = (remaining == frame_len);
        beat.payload_last  = (remaining <= 1);
        if (remaining > 0) remaining = remaining - 1'b1;
        if (remaining == 0) parse_ph = ipd_pkg::PH_SEARCH;
        expected_payload.push_back(beat);
      end
      default: begin
        parse_ph = ipd_pkg::PH_SEARCH;
        if (b == ipd_pkg::CHAR_PLUS) begin
          parse_ph = ipd_pkg::PH_TAG;
          tag_cnt  = '0;
          tag_bad  = 1'b0;
        end
      end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // rx side: one byte per call, random gap before it
  // -------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // valid stays high straight into the next beat when there is no gap
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    rx_count++;
    deframe_step(b);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold off rx until every predicted beat has come out
  task automatic drain_payload();
    rx.valid <= 1'b0;
    do @(posedge clk); while (expected_payload.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // pl side: random stall per beat
  // -------------------------------------------------------------------------

  initial begin
    pl.ready = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      ready_gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (ready_gap > 0) begin
        pl.ready <= 1'b0;
        repeat (ready_gap) @(posedge clk);
      end
      pl.ready <= 1'b1;
      // ready was high at this edge, so a valid here is a taken beat
      do @(posedge clk); while (!pl.valid);
    end
  end

  // -------------------------------------------------------------------------
  // beat checker
  // -------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin
    if (!rst && pl.valid && pl.ready) begin
      seen_beat.payload_byte  = pl.payload_byte;
      seen_beat.payload_first = pl.payload_first;
      seen_beat.payload_last  = pl.payload_last;
      if (expected_payload.size() == 0) begin
        flag_error($sformatf("unexpected beat: byte %02h first %0b last %0b",
                             seen_beat.payload_byte, seen_beat.payload_first,
                             seen_beat.payload_last));
      end else begin
        want_beat = expected_payload.pop_front();
        if (seen_beat.payload_byte  !== want_beat.payload_byte  ||
            seen_beat.payload_first !== want_beat.payload_first ||
            seen_beat.payload_last  !== want_beat.payload_last) begin
          flag_error($sformatf({"beat %0d: expected byte %02h first %0b last %0b,",
                                " got byte %02h first %0b last %0b"},
                               beats_checked, want_beat.payload_byte,
                               want_beat.payload_first, want_beat.payload_last,
                               seen_beat.payload_byte, seen_beat.payload_first,
                               seen_beat.payload_last));
        end
      end
      beats_checked++;
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  // well-formed header with random id, optional leading zeros and junk
  // after the digits, then len random payload bytes
  task automatic send_frame(input int len, input int zeros, input bit junk);
    int          i;
    int          id_len;
    logic [7:0]  c;
    send_byte(ipd_pkg::CHAR_PLUS);
    send_text("IPD");
    send_byte(ipd_pkg::CHAR_COMMA);
    id_len = $urandom_range(0, 3);
    for (i = 0; i < id_len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == ipd_pkg::CHAR_COMMA);
      send_byte(c);
    end
    send_byte(ipd_pkg::CHAR_COMMA);
    for (i = 0; i < zeros; i++) send_byte(ipd_pkg::CHAR_ZERO);
    send_text($sformatf("%0d", len));
    if (junk) begin
      // a non-digit stops the count, anything after it up to the colon is ignored
      do c = 8'($urandom_range(0, 255));
      while (c == ipd_pkg::CHAR_COLON ||
             (c >= ipd_pkg::CHAR_ZERO && c <= ipd_pkg::CHAR_NINE));
      send_byte(c);
      for (i = $urandom_range(0, 3); i > 0; i--) begin
        do c = 8'($urandom_range(0, 255)); while (c == ipd_pkg::CHAR_COLON);
        send_byte(c);
      end
    end
    send_byte(ipd_pkg::CHAR_COLON);
    for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // line noise, not counted as frame traffic
  task automatic send_noise(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)));
      noise_count++;
    end
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  task automatic test_basic_frames();
    send_text("+IPD,0,5:hello");
    // single-byte frames carry first and last together, extreme byte values
    send_text("+IPD,4,1:");
    send_byte(8'h00);
    send_text("+IPD,3,1:");
    send_byte(8'hFF);
    drain_payload();
  endtask

  task automatic test_zero_length();
    send_text("+IPD,0,0:");
    send_text("+IPD,1,2:ok");
    drain_payload();
  endtask

  task automatic test_bad_tags();
    // wrong letter, short tag, long tag, plus sign inside the tag, empty tag
    send_text("+IPX,0,3:abc");
    send_text("+IP,0,2:zz");
    send_text("+IPDD,0,2:zz");
    send_text("++IPD,0,2:zz");
    send_text("+,0,1:q");
    send_text("+IPD,0,2:hi");
    drain_payload();
  endtask

  task automatic test_length_stop();
    // digits after a non-digit are ignored
    send_text("+IPD,1,3x9:abc");
    // non-digit first gives zero length
    send_text("+IPD,1,x5:");
    send_text("+IPD,1,007:1234567");
    drain_payload();
  endtask

  task automatic test_payload_delimiters();
    // header characters inside the payload are data
    send_text("+IPD,2,9:+IPD,0,1:");
    send_text("+IPD,2,3:a:b");
    drain_payload();
  endtask

  task automatic test_length_saturation();
    int i;
    // 65537 clips to the counter maximum instead of wrapping to one, so the
    // first byte is not also the last; the frame stays open, so this runs last
    // and only a slice of its payload is sent
    send_text("+IPD,0,65537:");
    for (i = 0; i < SAT_SLICE; i++) send_byte(8'($urandom_range(0, 255)));
    drain_payload();
  endtask

  task automatic test_random_traffic();
    int base;
    int next_drain;
    int pick;
    int len;
    int i;
    base       = rx_count - noise_count;
    next_drain = DRAIN_EVERY;
    while (rx_count - noise_count - base < RANDOM_ITEMS) begin
      // some frames run with no idling at all
      no_idle = ($urandom_range(0, 99) < 15);
      pick    = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 6)       len = 0;
        else if (pick < 85) len = $urandom_range(1, 16);
        else                len = $urandom_range(17, 200);
        send_frame(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0,
                   ($urandom_range(0, 7) == 0));
      end else if (pick < 80) begin
        // bad tag of random capitals, then a frame tail
        send_byte(ipd_pkg::CHAR_PLUS);
        for (i = $urandom_range(0, 5); i > 0; i--) begin
          send_byte(8'(8'h41 + $urandom_range(0, 25)));
        end
        send_byte(ipd_pkg::CHAR_COMMA);
        send_text("0,3:abc");
      end else if (pick < 88) begin
        // header cut short, followed by noise
        if ($urandom_range(0, 1)) send_text("+IPD,");
        else                      send_text("+IPD,1,");
        send_noise($urandom_range(1, 6));
      end else begin
        send_noise($urandom_range(1, 8));
      end
      if (rx_count - noise_count - base >= next_drain) begin
        next_drain += DRAIN_EVERY;
        drain_payload();
      end
    end
    no_idle = 1'b0;
    drain_payload();
  endtask

  // -------------------------------------------------------------------------
  // sequence
  // -------------------------------------------------------------------------

  initial begin
    rst        = 1'b1;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    no_idle    = 1'b0;
    clear_parser();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_frames();
    test_zero_length();
    test_bad_tags();
    test_length_stop();
    test_payload_delimiters();
    test_random_traffic();
    test_length_saturation();

    // all beats should be out by now; leftovers count as failures
    if (expected_payload.size() != 0) begin
      flag_error($sformatf("%0d predicted beats never arrived", expected_payload.size()));
    end
    $display("covered %0d rx bytes (%0d noise), %0d frames with payload, %0d empty frames",
             rx_count, noise_count, frames_opened, zero_frames);
    $display("checked %0d payload beats, the last ones in a saturated-length frame, %0d errors",
             beats_checked, err_count);
    if (err_count == 0) begin
      $display("ipd_frame_deframer regression: pass");
    end else begin
      $display("ipd_frame_deframer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("ipd_frame_deframer regression: fail");
    $finish;
  end

endmodule
